// ----- hw/rtl/ipid_pkg.sv -----
// ipid_pkg: shared types and constants for the incremental pid heater drive
// no dependencies; used by the interfaces, the step logic and the top level
package ipid_pkg;

	localparam int TEMP_W  = 14;
	localparam int ERR_W   = 15;
	localparam int GAIN_W  = 16;
	localparam int DRIVE_W = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SETPOINT     = 3'd0,
		REG_GAIN_P       = 3'd1,
		REG_GAIN_I       = 3'd2,
		REG_GAIN_D       = 3'd3,
		REG_OUTPUT_LIMIT = 3'd4
	} reg_idx_t;

	localparam logic signed [TEMP_W-1:0] SETPOINT_RST = 14'sd224;
	localparam logic [GAIN_W-1:0]  GAIN_P_RST       = 16'd2560;
	localparam logic [GAIN_W-1:0]  GAIN_I_RST       = 16'd2560;
	localparam logic [GAIN_W-1:0]  GAIN_D_RST       = 16'd51;
	localparam logic [DRIVE_W-1:0] OUTPUT_LIMIT_RST = 16'd1500;

	typedef struct packed {
		logic signed [TEMP_W-1:0] setpoint;
		logic [GAIN_W-1:0]        gain_p;
		logic [GAIN_W-1:0]        gain_i;
		logic [GAIN_W-1:0]        gain_d;
		logic [DRIVE_W-1:0]       output_limit;
	} cfg_t;

	typedef struct packed {
		logic signed [ERR_W-1:0] error_prev;
		logic signed [ERR_W-1:0] error_prev2;
		logic [DRIVE_W-1:0]      command_acc;
	} state_t;

endpackage

// ----- hw/rtl/ipid_meas_if.sv -----
// ipid_meas_if: valid/ready channel carrying one temperature measurement
// depends on ipid_pkg
interface ipid_meas_if;
	logic valid;
	logic ready;
	logic signed [ipid_pkg::TEMP_W-1:0] measurement;

	modport source (output valid, output measurement, input ready);
	modport sink (input valid, input measurement, output ready);
endinterface

// ----- hw/rtl/ipid_drive_if.sv -----
// ipid_drive_if: valid/ready channel carrying one heater drive command
// depends on ipid_pkg
interface ipid_drive_if;
	logic valid;
	logic ready;
	logic [ipid_pkg::DRIVE_W-1:0] drive;

	modport source (output valid, output drive, input ready);
	modport sink (input valid, input drive, output ready);
endinterface

// ----- hw/rtl/incremental_pid_heater_drive_top.sv -----
// Incremental pid heater drive. Each measurement transfer yields one drive
// transfer via the input and then the output register. While the output is
// not stalled the block takes a new measurement every cycle: the pid update
// with its three gain multiplies and clamp runs from the input register into
// the output register and the kept state, so the sustained rate is one item
// per cycle, set by the update loop through the kept command. Configuration
// registers must be written through cfg_we/cfg_index/cfg_wdata only while no
// item is in flight (not enforced by the block); unknown indexes are ignored.
// depends on ipid_pkg, ipid_meas_if, ipid_drive_if, ipid_step
module incremental_pid_heater_drive_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [ipid_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [ipid_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	ipid_meas_if.sink                         sample,
	ipid_drive_if.source                      result
);
	ipid_pkg::cfg_t   cfg_q;
	ipid_pkg::state_t st_q;
	ipid_pkg::state_t st_next;

	logic                               valid_s1;
	logic signed [ipid_pkg::TEMP_W-1:0] meas_s1;
	logic                               valid_s2;
	logic [ipid_pkg::DRIVE_W-1:0]       drive_s2;
	logic                               advance;

	assign advance      = valid_s1 && (!valid_s2 || result.ready);
	assign sample.ready = !valid_s1 || advance;
	assign result.valid = valid_s2;
	assign result.drive = drive_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.setpoint     <= ipid_pkg::SETPOINT_RST;
			cfg_q.gain_p       <= ipid_pkg::GAIN_P_RST;
			cfg_q.gain_i       <= ipid_pkg::GAIN_I_RST;
			cfg_q.gain_d       <= ipid_pkg::GAIN_D_RST;
			cfg_q.output_limit <= ipid_pkg::OUTPUT_LIMIT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ipid_pkg::REG_SETPOINT:     cfg_q.setpoint <= $signed(cfg_wdata[13:0]);
				ipid_pkg::REG_GAIN_P:       cfg_q.gain_p <= cfg_wdata;
				ipid_pkg::REG_GAIN_I:       cfg_q.gain_i <= cfg_wdata;
				ipid_pkg::REG_GAIN_D:       cfg_q.gain_d <= cfg_wdata;
				ipid_pkg::REG_OUTPUT_LIMIT: cfg_q.output_limit <= cfg_wdata;
				default: ;
			endcase
		end
	end

	ipid_step u_step (
		.meas (meas_s1),
		.cfg  (cfg_q),
		.cur  (st_q),
		.nxt  (st_next)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample.ready) begin
			valid_s1 <= sample.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample.valid && sample.ready) begin
			meas_s1 <= sample.measurement;
		end
	end

	// kept state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= '0;
			valid_s2 <= 1'b0;
		end else begin
			if (advance) begin
				st_q     <= st_next;
				valid_s2 <= 1'b1;
			end else if (result.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			drive_s2 <= st_next.command_acc;
		end
	end
endmodule

// ----- hw/rtl/ipid_step.sv -----
// ipid_step: one velocity-form pid update with clamp, purely combinational
// depends on ipid_pkg
module ipid_step (
	input  logic signed [ipid_pkg::TEMP_W-1:0] meas,
	input  ipid_pkg::cfg_t                     cfg,
	input  ipid_pkg::state_t                   cur,
	output ipid_pkg::state_t                   nxt
);
	logic signed [14:0] err;
	logic signed [15:0] de;
	logic signed [15:0] se;
	logic signed [17:0] dde;
	logic signed [32:0] prod_p;
	logic signed [32:0] prod_i;
	logic signed [34:0] prod_d;
	logic signed [35:0] sum;
	logic signed [24:0] inc;
	logic signed [25:0] acc_next;

	assign err = {cfg.setpoint[13], cfg.setpoint} - {meas[13], meas};
	assign de  = {err[14], err} - {cur.error_prev[14], cur.error_prev};
	assign se  = {err[14], err} + {cur.error_prev[14], cur.error_prev};
	assign dde = {{3{err[14]}}, err}
		- {{2{cur.error_prev[14]}}, cur.error_prev, 1'b0}
		+ {{3{cur.error_prev2[14]}}, cur.error_prev2};

	assign prod_p = $signed({1'b0, cfg.gain_p}) * de;
	assign prod_i = $signed({1'b0, cfg.gain_i}) * se;
	assign prod_d = $signed({1'b0, cfg.gain_d}) * dde;

	assign sum = {{2{prod_p[32]}}, prod_p, 1'b0}
		+ {{3{prod_i[32]}}, prod_i}
		+ {prod_d[34], prod_d};

	// floor division by 2048
	assign inc = sum[35:11];
	assign acc_next = $signed({10'b0, cur.command_acc}) + {inc[24], inc};

	always_comb begin
		nxt.error_prev  = err;
		nxt.error_prev2 = cur.error_prev;
		if (acc_next[25]) begin
			nxt.command_acc = '0;
		end else if (acc_next[24:0] > {9'b0, cfg.output_limit}) begin
			nxt.command_acc = cfg.output_limit;
		end else begin
			nxt.command_acc = acc_next[15:0];
		end
	end
endmodule

// ----- hw/rtl/ipid_checker.sv -----
// ipid_checker: port-level assertions for the pid heater drive, bound to the top
// depends on ipid_pkg and the top level ports
module ipid_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            in_valid,
	input logic                            in_ready,
	input logic                            out_valid,
	input logic                            out_ready,
	input logic [ipid_pkg::DRIVE_W-1:0]    out_drive
);
	logic in_xfer;

	assign in_xfer = in_valid && in_ready;

	// output register empties on reset
	a_reset_empty: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("result valid during reset");

	// stalled result holds
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_drive))
		else $error("stalled result changed");

	// an empty output stage never blocks the input
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input blocked with empty output");

	// a new result comes from an earlier input transfer
	a_result_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_xfer, 2))
		else $error("result without matching input transfer");
endmodule

bind incremental_pid_heater_drive_top ipid_checker u_ipid_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (sample.valid),
	.in_ready  (sample.ready),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.out_drive (result.drive)
);

// ----- bench/testbench.sv -----
`timescale 1ns / 100ps
// testbench: feeds temperature measurements into the incremental pid heater drive and
// checks every drive transfer against a velocity-form pid model kept in step with it
// depends on ipid_pkg, ipid_meas_if, ipid_drive_if, incremental_pid_heater_drive_top
module testbench;

	typedef enum logic {ROW_MEAS, ROW_CFG} row_kind_t;

	typedef struct packed {
		row_kind_t                          kind;
		logic [ipid_pkg::CFG_IDX_W-1:0]     idx;
		logic [ipid_pkg::CFG_DATA_W-1:0]    data;
		logic signed [ipid_pkg::TEMP_W-1:0] meas;
		logic                               known;
		logic [ipid_pkg::DRIVE_W-1:0]       drive;
	} row_t;

	localparam logic [ipid_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
	localparam logic [ipid_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
	localparam int PHASES          = 10;
	localparam int ITEMS_PER_PHASE = 170;
	localparam int SETTLE_CYCLES   = 4;
	localparam int PRESSURE_CYCLES = 80;
	localparam int MAX_PRINTED     = 30;

	logic                            clk;
	logic                            arst_n;
	logic                            cfg_we;
	logic [ipid_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [ipid_pkg::CFG_DATA_W-1:0] cfg_wdata;

	ipid_meas_if  meas_ch ();
	ipid_drive_if drive_ch ();

	incremental_pid_heater_drive_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.sample    (meas_ch),
		.result    (drive_ch)
	);

	ipid_pkg::cfg_t                    pid_cfg;
	logic signed [ipid_pkg::ERR_W-1:0] err_last;
	logic signed [ipid_pkg::ERR_W-1:0] err_older;
	logic [ipid_pkg::DRIVE_W-1:0]      drive_cmd;
	logic [ipid_pkg::DRIVE_W-1:0]      drive_expected [$];
	logic [ipid_pkg::DRIVE_W-1:0]      drive_want;
	int                                fail_count = 0;
	bit                                idle_on = 1'b0;
	bit                                pressure_req = 1'b0;
	int                                hold_left = 0;

	row_t directed_rows [$] = '{
		'{ROW_MEAS, '0, '0, 14'sd224, 1'b1, 16'd0},
		'{ROW_MEAS, '0, '0, 14'h2000, 1'b1, 16'd1500},
		'{ROW_MEAS, '0, '0, 14'sd8191, 1'b1, 16'd0},
		'{ROW_MEAS, '0, '0, 14'sd0, 1'b0, '0},
		'{ROW_MEAS, '0, '0, 14'sd200, 1'b0, '0},
		'{ROW_MEAS, '0, '0, 14'sd230, 1'b0, '0},
		'{ROW_CFG, ipid_pkg::REG_OUTPUT_LIMIT, 16'd0, '0, 1'b0, '0},
		'{ROW_MEAS, '0, '0, 14'h2000, 1'b1, 16'd0},
		'{ROW_CFG, ipid_pkg::REG_OUTPUT_LIMIT, 16'hFFFF, '0, 1'b0, '0},
		'{ROW_CFG, ipid_pkg::REG_GAIN_P, 16'hFFFF, '0, 1'b0, '0},
		'{ROW_CFG, ipid_pkg::REG_GAIN_I, 16'hFFFF, '0, 1'b0, '0},
		'{ROW_CFG, ipid_pkg::REG_GAIN_D, 16'hFFFF, '0, 1'b0, '0},
		'{ROW_MEAS, '0, '0, 14'h2000, 1'b0, '0},
		'{ROW_MEAS, '0, '0, -14'sd8000, 1'b0, '0},
		// limit dropped under the kept command
		'{ROW_CFG, ipid_pkg::REG_OUTPUT_LIMIT, 16'd1000, '0, 1'b0, '0},
		'{ROW_MEAS, '0, '0, -14'sd8000, 1'b0, '0},
		'{ROW_CFG, ipid_pkg::REG_SETPOINT, 16'h1FFF, '0, 1'b0, '0},
		'{ROW_MEAS, '0, '0, 14'h2000, 1'b0, '0},
		'{ROW_CFG, ipid_pkg::REG_SETPOINT, 16'hE000, '0, 1'b0, '0},
		'{ROW_MEAS, '0, '0, 14'sd8191, 1'b0, '0},
		'{ROW_MEAS, '0, '0, 14'sd8191, 1'b0, '0},
		'{ROW_CFG, ipid_pkg::REG_GAIN_P, 16'd0, '0, 1'b0, '0},
		'{ROW_CFG, ipid_pkg::REG_GAIN_I, 16'd0, '0, 1'b0, '0},
		'{ROW_CFG, ipid_pkg::REG_GAIN_D, 16'd0, '0, 1'b0, '0},
		'{ROW_MEAS, '0, '0, -14'sd5, 1'b0, '0},
		// writes to unmapped indexes must leave everything alone
		'{ROW_CFG, REG_SPARE_LO, 16'hFFFF, '0, 1'b0, '0},
		'{ROW_CFG, REG_SPARE_HI, 16'h0000, '0, 1'b0, '0},
		'{ROW_MEAS, '0, '0, 14'sd0, 1'b0, '0},
		'{ROW_CFG, ipid_pkg::REG_SETPOINT, 16'd224, '0, 1'b0, '0},
		'{ROW_CFG, ipid_pkg::REG_GAIN_P, 16'd2560, '0, 1'b0, '0},
		'{ROW_CFG, ipid_pkg::REG_GAIN_I, 16'd2560, '0, 1'b0, '0},
		'{ROW_CFG, ipid_pkg::REG_GAIN_D, 16'd51, '0, 1'b0, '0},
		'{ROW_CFG, ipid_pkg::REG_OUTPUT_LIMIT, 16'd1500, '0, 1'b0, '0},
		'{ROW_MEAS, '0, '0, 14'sd224, 1'b0, '0}
	};

	// one velocity-form update: increment is floor(sum / 2048), then clamp
	function automatic logic [ipid_pkg::DRIVE_W-1:0] advance_pid(
		input logic signed [ipid_pkg::TEMP_W-1:0] meas);
		longint err;
		longint weighted;
		longint next_cmd;
		err = longint'($signed(pid_cfg.setpoint)) - longint'(meas);
		weighted = 2 * longint'(pid_cfg.gain_p) * (err - longint'(err_last))
			+ longint'(pid_cfg.gain_i) * (err + longint'(err_last))
			+ longint'(pid_cfg.gain_d)
			* (err - 2 * longint'(err_last) + longint'(err_older));
		next_cmd = longint'(drive_cmd) + (weighted >>> 11);
		if (next_cmd < 0)
			next_cmd = 0;
		else if (next_cmd > longint'(pid_cfg.output_limit))
			next_cmd = longint'(pid_cfg.output_limit);
		drive_cmd = next_cmd[ipid_pkg::DRIVE_W-1:0];
		err_older = err_last;
		err_last = err[ipid_pkg::ERR_W-1:0];
		return drive_cmd;
	endfunction

	function automatic int pick_setpoint();
		case ($urandom_range(0, 7))
			0: return -8192;
			1: return 8191;
			default: return int'($urandom_range(0, 1600)) - 200;
		endcase
	endfunction

	function automatic logic [ipid_pkg::CFG_DATA_W-1:0] pick_gain();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			default: return 16'($urandom_range(0, 4096));
		endcase
	endfunction

	function automatic logic [ipid_pkg::CFG_DATA_W-1:0] pick_limit();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			default: return 16'($urandom_range(1, 4000));
		endcase
	endfunction

	task automatic report_mismatch(input string what,
		input logic [ipid_pkg::DRIVE_W-1:0] got,
		input logic [ipid_pkg::DRIVE_W-1:0] want);
		if (fail_count < MAX_PRINTED)
			$display("mismatch (%s) at %0t: drive %0d, expected %0d", what, $time, got, want);
		fail_count++;
	endtask

	task automatic write_reg(input logic [ipid_pkg::CFG_IDX_W-1:0] idx,
		input logic [ipid_pkg::CFG_DATA_W-1:0] data);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_wdata = data;
		case (idx)
			ipid_pkg::REG_SETPOINT:     pid_cfg.setpoint = data[ipid_pkg::TEMP_W-1:0];
			ipid_pkg::REG_GAIN_P:       pid_cfg.gain_p = data;
			ipid_pkg::REG_GAIN_I:       pid_cfg.gain_i = data;
			ipid_pkg::REG_GAIN_D:       pid_cfg.gain_d = data;
			ipid_pkg::REG_OUTPUT_LIMIT: pid_cfg.output_limit = data;
			default: ;
		endcase
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic wait_idle();
		meas_ch.valid = 1'b0;
		while (drive_expected.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// called at a falling edge, returns at the falling edge after the transfer
	task automatic send_meas(input logic signed [ipid_pkg::TEMP_W-1:0] m,
		input logic known, input logic [ipid_pkg::DRIVE_W-1:0] fixed);
		logic [ipid_pkg::DRIVE_W-1:0] predicted;
		if (idle_on && $urandom_range(0, 5) == 0) begin
			meas_ch.valid = 1'b0;
			repeat ($urandom_range(1, 14)) @(negedge clk);
		end
		meas_ch.valid = 1'b1;
		meas_ch.measurement = m;
		do @(posedge clk); while (!meas_ch.ready);
		predicted = advance_pid(m);
		drive_expected.push_back(known ? fixed : predicted);
		@(negedge clk);
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	// receiver: random stalls, plus one long hold-off so the block backs up
	initial begin
		drive_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				hold_left--;
				drive_ch.ready = 1'b0;
			end else if (pressure_req) begin
				pressure_req = 1'b0;
				hold_left = PRESSURE_CYCLES - 1;
				drive_ch.ready = 1'b0;
			end else if (idle_on && $urandom_range(0, 9) == 0) begin
				hold_left = $urandom_range(0, 13);
				drive_ch.ready = 1'b0;
			end else begin
				drive_ch.ready = 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && drive_ch.valid && drive_ch.ready) begin
			if (drive_expected.size() == 0) begin
				report_mismatch("no transfer pending", drive_ch.drive, '0);
			end else begin
				drive_want = drive_expected.pop_front();
				if (drive_ch.drive !== drive_want)
					report_mismatch("drive", drive_ch.drive, drive_want);
			end
		end
	end

	initial begin
		int sp;
		int offset;
		int raw;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		meas_ch.valid = 1'b0;
		meas_ch.measurement = '0;
		pid_cfg.setpoint = ipid_pkg::SETPOINT_RST;
		pid_cfg.gain_p = ipid_pkg::GAIN_P_RST;
		pid_cfg.gain_i = ipid_pkg::GAIN_I_RST;
		pid_cfg.gain_d = ipid_pkg::GAIN_D_RST;
		pid_cfg.output_limit = ipid_pkg::OUTPUT_LIMIT_RST;
		err_last = '0;
		err_older = '0;
		drive_cmd = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		idle_on = 1'b1;
		foreach (directed_rows[r]) begin
			if (directed_rows[r].kind == ROW_CFG) begin
				if (r == 0 || directed_rows[r-1].kind != ROW_CFG)
					wait_idle();
				write_reg(directed_rows[r].idx, directed_rows[r].data);
			end else begin
				send_meas(directed_rows[r].meas, directed_rows[r].known, directed_rows[r].drive);
			end
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			wait_idle();
			idle_on = (ph < PHASES - 2) && (ph % 3 != 1);
			sp = pick_setpoint();
			write_reg(ipid_pkg::REG_SETPOINT, {2'($urandom), 14'(sp)});
			write_reg(ipid_pkg::REG_GAIN_P, pick_gain());
			write_reg(ipid_pkg::REG_GAIN_I, pick_gain());
			write_reg(ipid_pkg::REG_GAIN_D, pick_gain());
			write_reg(ipid_pkg::REG_OUTPUT_LIMIT, pick_limit());
			if ($urandom_range(0, 2) == 0)
				write_reg(REG_SPARE_LO + 3'($urandom_range(0, 2)), 16'($urandom));
			if (ph == 2)
				pressure_req = 1'b1;
			offset = int'($urandom_range(0, 64)) - 32;
			for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
				if ($urandom_range(0, 7) == 0) begin
					send_meas(14'($urandom), 1'b0, '0);
				end else begin
					// plant drifting around the setpoint
					offset += int'($urandom_range(0, 16)) - 8;
					if (offset > 300)
						offset = 300;
					if (offset < -300)
						offset = -300;
					raw = sp + offset;
					if (raw > 8191)
						raw = 8191;
					if (raw < -8192)
						raw = -8192;
					send_meas(14'(raw), 1'b0, '0);
				end
			end
		end

		meas_ch.valid = 1'b0;
		while (drive_expected.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end
endmodule
